/* sv/dns_message_structure_parser_top_defines.svh */
// Assertion macros shared by the DNS parser checker.
`ifndef DNS_MESSAGE_STRUCTURE_PARSER_TOP_DEFINES_SVH
`define DNS_MESSAGE_STRUCTURE_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DNSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DNSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked during reset.
`define DNSP_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/dnsp_pkg.sv */
// Types, codes and helper functions of the DNS message structure parser.
`default_nettype none

package dnsp_pkg;

  // Message sections.
  typedef enum logic [2:0] {
    SEC_HDR   = 3'd0,
    SEC_QD    = 3'd1,
    SEC_AN    = 3'd2,
    SEC_NS    = 3'd3,
    SEC_AR    = 3'd4,
    SEC_TRAIL = 3'd5
  } sec_t;

  // Field kinds of one classified byte.
  typedef enum logic [3:0] {
    KIND_HDR     = 4'd0,
    KIND_LABLEN  = 4'd1,
    KIND_LABTEXT = 4'd2,
    KIND_PTRHI   = 4'd3,
    KIND_PTRLO   = 4'd4,
    KIND_NAMEEND = 4'd5,
    KIND_TYPE    = 4'd6,
    KIND_CLASS   = 4'd7,
    KIND_TTL     = 4'd8,
    KIND_RDLEN   = 4'd9,
    KIND_RDATA   = 4'd10,
    KIND_TRAIL   = 4'd11,
    KIND_IGN     = 4'd12
  } kind_t;

  // Error codes.
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_LABEL = 2'd1,
    ERR_TRUNC = 2'd2
  } err_t;

  // Position inside a question or resource record.
  typedef enum logic [3:0] {
    PH_NAME   = 4'd0,
    PH_TEXT   = 4'd1,
    PH_PTRLO  = 4'd2,
    PH_TYPE0  = 4'd3,
    PH_TYPE1  = 4'd4,
    PH_CLASS0 = 4'd5,
    PH_CLASS1 = 4'd6,
    PH_TTL0   = 4'd7,
    PH_TTL1   = 4'd8,
    PH_TTL2   = 4'd9,
    PH_TTL3   = 4'd10,
    PH_RDLEN0 = 4'd11,
    PH_RDLEN1 = 4'd12,
    PH_RDATA  = 4'd13
  } phase_t;

  // Header layout: twelve bytes, counts in byte pairs 2 to 5.
  localparam logic [3:0] HDR_LEN       = 4'd12;
  localparam logic [3:0] HDR_CNT_FIRST = 4'd4;
  localparam logic [3:0] HDR_CNT_LAST  = 4'd11;
  localparam logic [2:0] HDR_PAIR_QD   = 3'd2;
  localparam logic [2:0] HDR_PAIR_AN   = 3'd3;
  localparam logic [2:0] HDR_PAIR_NS   = 3'd4;
  localparam logic [2:0] HDR_PAIR_AR   = 3'd5;

  // Label length byte classes.
  localparam logic [7:0] LABEL_MAX_PLUS1 = 8'd64;
  localparam logic [7:0] PTR_MARK        = 8'hC0;

  localparam int PTR_W = 14;
  localparam int CNT_W = 16;

  // First section at or after from whose record count is nonzero; bit 0 of
  // nz belongs to the question section. Trailing if none is left.
  function automatic sec_t next_sec(input logic [2:0] from, input logic [3:0] nz);
    sec_t res;
    logic found;
    res   = SEC_TRAIL;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!found && (from <= 3'(i + 1)) && nz[i]) begin
        res   = sec_t'(3'(i + 1));
        found = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* sv/dns_message_structure_parser_top.sv */
// DNS message structure parser: classifies each message byte by section and field.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_stall, in_data_byte,       | into block
//           | in_end_of_packet                        |
//   out     | out_valid, out_stall, out_section,      | out of block
//           | out_field_kind, out_pointer_offset,     |
//           | out_error_code, out_packet_done         |
//
// One item enters per cycle while in_stall is low; it passes through the input
// register, then the result register, to the out ports. The parse state update
// is a single pass of counter and compare logic between these two registers.
// Reset (rst_n low, synchronous) empties both registers and clears the parse
// state; the state also returns to its reset value after the last byte.
// A stall on the result side holds the result register; in_stall is high while
// both registers hold an item and out_stall is high, so at most two items wait.
`default_nettype none

module dns_message_structure_parser_top import dnsp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_packet,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_section,
  output logic [3:0]       out_field_kind,
  output logic [13:0]      out_pointer_offset,
  output logic [1:0]       out_error_code,
  output logic             out_packet_done
);

  // Input register.
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_eop_r;

  // Result register.
  logic             out_valid_r;
  sec_t             res_sec_r;
  kind_t            res_kind_r;
  logic [PTR_W-1:0] res_ptr_r;
  err_t             res_err_r;
  logic             res_done_r;

  // Parse state.
  logic [3:0]       pos_r, pos_nxt;
  logic [CNT_W-1:0] qd_r, qd_nxt, an_r, an_nxt, ns_r, ns_nxt, ar_r, ar_nxt;
  sec_t             sec_r, sec_nxt;
  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [7:0]       held_r, held_nxt;
  err_t             err_r, err_nxt;

  // Classification of the byte in the input register.
  sec_t             sec_eff;
  phase_t           ph_eff;
  kind_t            kind;
  logic [PTR_W-1:0] ptr;
  err_t             err;
  logic             fin;
  logic [CNT_W-1:0] cnt_dec;
  logic [7:0]       b;

  logic advance;
  logic fire;
  logic in_take;

  // Handshake: the input register moves on whenever the result register is free.
  assign advance   = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  assign b = s1_byte_r;

  // Next parse state and classification of the current byte.
  always_comb begin
    pos_nxt   = pos_r;
    qd_nxt    = qd_r;
    an_nxt    = an_r;
    ns_nxt    = ns_r;
    ar_nxt    = ar_r;
    sec_nxt   = sec_r;
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    held_nxt  = held_r;
    err_nxt   = err_r;
    kind      = KIND_HDR;
    ptr       = '0;
    err       = ERR_NONE;
    fin       = 1'b0;
    cnt_dec   = '0;
    sec_eff   = (sec_r > SEC_TRAIL) ? SEC_TRAIL : sec_r;
    ph_eff    = (phase_r > PH_RDATA) ? PH_NAME : phase_r;

    if (err_r != ERR_NONE) begin
      kind = KIND_IGN;
      err  = err_r;
    end else begin
      case (sec_eff)
        SEC_HDR: begin
          kind = KIND_HDR;
          // Record counts are big-endian byte pairs.
          if (pos_r inside {[HDR_CNT_FIRST:HDR_CNT_LAST]}) begin
            case (pos_r[3:1])
              HDR_PAIR_QD: qd_nxt = {qd_r[7:0], b};
              HDR_PAIR_AN: an_nxt = {an_r[7:0], b};
              HDR_PAIR_NS: ns_nxt = {ns_r[7:0], b};
              HDR_PAIR_AR: ar_nxt = {ar_r[7:0], b};
              default: ;
            endcase
          end
          if (pos_r < HDR_LEN) begin
            pos_nxt = pos_r + 4'd1;
          end
          if (pos_r >= HDR_CNT_LAST) begin
            sec_nxt   = next_sec(SEC_QD, {ar_nxt != '0, ns_nxt != '0,
                                          an_nxt != '0, qd_nxt != '0});
            phase_nxt = PH_NAME;
          end
        end
        SEC_TRAIL: begin
          kind    = KIND_TRAIL;
          sec_nxt = SEC_TRAIL;
        end
        default: begin
          case (ph_eff)
            PH_NAME: begin
              if (b == 8'd0) begin
                kind      = KIND_NAMEEND;
                phase_nxt = PH_TYPE0;
              end else if (b < LABEL_MAX_PLUS1) begin
                kind      = KIND_LABLEN;
                rem_nxt   = {8'd0, b};
                phase_nxt = PH_TEXT;
              end else if (b >= PTR_MARK) begin
                kind      = KIND_PTRHI;
                held_nxt  = b;
                phase_nxt = PH_PTRLO;
              end else begin
                kind    = KIND_LABLEN;
                err_nxt = ERR_LABEL;
                err     = ERR_LABEL;
              end
            end
            PH_TEXT: begin
              kind    = KIND_LABTEXT;
              rem_nxt = rem_r - 16'd1;
              if (rem_nxt == '0) begin
                phase_nxt = PH_NAME;
              end
            end
            PH_PTRLO: begin
              kind      = KIND_PTRLO;
              ptr       = {held_r[5:0], b};
              phase_nxt = PH_TYPE0;
            end
            PH_TYPE0: begin
              kind      = KIND_TYPE;
              phase_nxt = PH_TYPE1;
            end
            PH_TYPE1: begin
              kind      = KIND_TYPE;
              phase_nxt = PH_CLASS0;
            end
            PH_CLASS0: begin
              kind      = KIND_CLASS;
              phase_nxt = PH_CLASS1;
            end
            PH_CLASS1: begin
              kind = KIND_CLASS;
              // A question ends after its class; a record goes on to its TTL.
              if (sec_eff == SEC_QD) begin
                fin = 1'b1;
              end else begin
                phase_nxt = PH_TTL0;
              end
            end
            PH_TTL0: begin
              kind      = KIND_TTL;
              phase_nxt = PH_TTL1;
            end
            PH_TTL1: begin
              kind      = KIND_TTL;
              phase_nxt = PH_TTL2;
            end
            PH_TTL2: begin
              kind      = KIND_TTL;
              phase_nxt = PH_TTL3;
            end
            PH_TTL3: begin
              kind      = KIND_TTL;
              phase_nxt = PH_RDLEN0;
            end
            PH_RDLEN0: begin
              kind      = KIND_RDLEN;
              held_nxt  = b;
              phase_nxt = PH_RDLEN1;
            end
            PH_RDLEN1: begin
              kind    = KIND_RDLEN;
              rem_nxt = {held_r, b};
              if (rem_nxt == '0) begin
                fin = 1'b1;
              end else begin
                phase_nxt = PH_RDATA;
              end
            end
            default: begin
              kind    = KIND_RDATA;
              rem_nxt = rem_r - 16'd1;
              if (rem_nxt == '0) begin
                fin = 1'b1;
              end
            end
          endcase

          // End of a question or record: count it off, move on when the section is done.
          if (fin) begin
            phase_nxt = PH_NAME;
            case (sec_eff)
              SEC_QD: begin
                cnt_dec = qd_r - 16'd1;
                qd_nxt  = cnt_dec;
              end
              SEC_AN: begin
                cnt_dec = an_r - 16'd1;
                an_nxt  = cnt_dec;
              end
              SEC_NS: begin
                cnt_dec = ns_r - 16'd1;
                ns_nxt  = cnt_dec;
              end
              default: begin
                cnt_dec = ar_r - 16'd1;
                ar_nxt  = cnt_dec;
              end
            endcase
            if (cnt_dec == '0) begin
              sec_nxt = next_sec(sec_eff + 3'd1, {ar_nxt != '0, ns_nxt != '0,
                                                  an_nxt != '0, qd_nxt != '0});
            end
          end
        end
      endcase
    end

    // A last byte that leaves the structure open flags truncation.
    if (s1_eop_r && err == ERR_NONE && sec_nxt != SEC_TRAIL) begin
      err = ERR_TRUNC;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_eop_r  <= in_end_of_packet;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_sec_r  <= sec_eff;
      res_kind_r <= kind;
      res_ptr_r  <= ptr;
      res_err_r  <= err;
      res_done_r <= s1_eop_r;
    end
  end

  // Parse state; everything returns to reset after the last byte.
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && s1_eop_r)) begin
      pos_r   <= '0;
      qd_r    <= '0;
      an_r    <= '0;
      ns_r    <= '0;
      ar_r    <= '0;
      sec_r   <= SEC_HDR;
      phase_r <= PH_NAME;
      rem_r   <= '0;
      held_r  <= '0;
      err_r   <= ERR_NONE;
    end else if (fire) begin
      pos_r   <= pos_nxt;
      qd_r    <= qd_nxt;
      an_r    <= an_nxt;
      ns_r    <= ns_nxt;
      ar_r    <= ar_nxt;
      sec_r   <= sec_nxt;
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      held_r  <= held_nxt;
      err_r   <= err_nxt;
    end
  end

  assign out_section        = res_sec_r;
  assign out_field_kind     = res_kind_r;
  assign out_pointer_offset = res_ptr_r;
  assign out_error_code     = res_err_r;
  assign out_packet_done    = res_done_r;

endmodule

`default_nettype wire

/* sv/dnsp_checker.sv */
// Port-level checker for the DNS parser and its bind to the top level.
`default_nettype none
`include "dns_message_structure_parser_top_defines.svh"

module dnsp_checker import dnsp_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  in_data_byte,
  input wire logic        in_end_of_packet,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_section,
  input wire logic [3:0]  out_field_kind,
  input wire logic [13:0] out_pointer_offset,
  input wire logic [1:0]  out_error_code,
  input wire logic        out_packet_done
);

  // A stalled input item stays offered and unchanged.
  `DNSP_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data_byte) && $stable(in_end_of_packet), "stalled input item changed")

  // A stalled result keeps its payload.
  `DNSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_section) && $stable(out_field_kind) && $stable(out_pointer_offset) && $stable(out_error_code) && $stable(out_packet_done), "stalled item changed")

  // Reset empties the result side.
  `DNSP_ASSERT_ALWAYS_NEXT(a_rst_empty, !rst_n, !out_valid, "item shown after reset")

  // A pointer offset only appears on the pointer's second byte.
  `DNSP_ASSERT_NOW(a_ptr_only_lo, out_valid && out_field_kind != KIND_PTRLO, out_pointer_offset == '0, "stray pointer offset")

  // Ignored bytes always carry the latched error.
  `DNSP_ASSERT_NOW(a_ign_err, out_valid && out_field_kind == KIND_IGN, out_error_code == ERR_LABEL, "ignored byte without error")

endmodule

bind dns_message_structure_parser_top dnsp_checker u_dnsp_checker (.*);

`default_nettype wire

/* sim/tb_dns_message_structure_parser_top.sv */
// Self-checking testbench for the DNS message structure parser, byte stream in, class out.
module tb_dns_message_structure_parser_top;
  import dnsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int QUIET_TAIL  = 200;
  localparam int TARGET_BYTES = 1550;

  // One byte of a message as the sender offers it.
  typedef struct {
    logic [7:0] data;
    logic       eop;
    logic       drain_first;
  } msg_byte_t;

  // Classification of one byte.
  typedef struct {
    sec_t        sec;
    kind_t       kind;
    logic [13:0] ptr;
    err_t        err;
    logic        done;
  } byte_class_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_end_of_packet = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_section;
  logic [3:0]  out_field_kind;
  logic [13:0] out_pointer_offset;
  logic [1:0]  out_error_code;
  logic        out_packet_done;

  msg_byte_t   byte_feed_q[$];
  byte_class_t expected_class_q[$];
  logic [7:0]  pkt_bytes[$];
  msg_byte_t   next_byte;

  int total_bytes = 0;
  int bytes_taken = 0;
  int gap_left = 0;
  int mismatches = 0;
  int results_checked = 0;
  int messages_done = 0;
  int truncations = 0;
  int label_errors = 0;
  int pointers_seen = 0;
  int cycle_count = 0;

  // Parser state mirrored by the predictor.
  logic [3:0]  hdr_pos;
  logic [15:0] rec_left [1:4];
  sec_t        cur_sec;
  phase_t      rec_phase;
  logic [15:0] remain;
  logic [7:0]  high_byte;
  err_t        err_latch;

  dns_message_structure_parser_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_end_of_packet   (in_end_of_packet),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_section        (out_section),
    .out_field_kind     (out_field_kind),
    .out_pointer_offset (out_pointer_offset),
    .out_error_code     (out_error_code),
    .out_packet_done    (out_packet_done)
  );

  always #6 clk = ~clk;

  // Return the parser to its idle state, as after reset or a last byte.
  function automatic void clear_parse_state();
    hdr_pos = 4'd0;
    for (int s = 1; s <= 4; s++) rec_left[s] = 16'd0;
    cur_sec   = SEC_HDR;
    rec_phase = PH_NAME;
    remain    = 16'd0;
    high_byte = 8'd0;
    err_latch = ERR_NONE;
  endfunction

  // Lowest section at or after from that still has records; trailing otherwise.
  function automatic sec_t first_busy_sec(input logic [2:0] from);
    sec_t found;
    found = SEC_TRAIL;
    for (int s = 4; s >= 1; s--) begin
      if (s >= int'(from) && rec_left[s] != 16'd0) found = sec_t'(s);
    end
    return found;
  endfunction

  // Close one question or record and move on when the section is used up.
  function automatic void finish_record();
    rec_left[cur_sec] = rec_left[cur_sec] - 16'd1;
    rec_phase = PH_NAME;
    if (rec_left[cur_sec] == 16'd0) cur_sec = first_busy_sec(cur_sec + 3'd1);
  endfunction

  // Classify one byte and advance the parse state.
  function automatic byte_class_t classify_byte(input logic [7:0] b, input logic eop);
    byte_class_t r;
    int idx;
    r.sec  = cur_sec;
    r.kind = KIND_HDR;
    r.ptr  = 14'd0;
    r.err  = ERR_NONE;
    r.done = eop;
    if (err_latch != ERR_NONE) begin
      r.kind = KIND_IGN;
      r.err  = err_latch;
    end else if (cur_sec == SEC_HDR) begin
      // Header bytes 4 to 11 hold the four record counts, high byte first.
      if (hdr_pos >= HDR_CNT_FIRST && hdr_pos <= HDR_CNT_LAST) begin
        idx = (int'(hdr_pos) - 4) / 2 + 1;
        rec_left[idx] = {rec_left[idx][7:0], b};
      end
      if (hdr_pos >= HDR_CNT_LAST) begin
        cur_sec   = first_busy_sec(3'(SEC_QD));
        rec_phase = PH_NAME;
      end
      if (hdr_pos < HDR_LEN) hdr_pos = hdr_pos + 4'd1;
    end else if (cur_sec == SEC_TRAIL) begin
      r.kind = KIND_TRAIL;
    end else begin
      case (rec_phase)
        PH_NAME: begin
          if (b == 8'd0) begin
            r.kind    = KIND_NAMEEND;
            rec_phase = PH_TYPE0;
          end else if (b < LABEL_MAX_PLUS1) begin
            r.kind    = KIND_LABLEN;
            remain    = {8'd0, b};
            rec_phase = PH_TEXT;
          end else if (b >= PTR_MARK) begin
            r.kind    = KIND_PTRHI;
            high_byte = b;
            rec_phase = PH_PTRLO;
          end else begin
            r.kind    = KIND_LABLEN;
            err_latch = ERR_LABEL;
            r.err     = ERR_LABEL;
          end
        end
        PH_TEXT: begin
          r.kind = KIND_LABTEXT;
          remain = remain - 16'd1;
          if (remain == 16'd0) rec_phase = PH_NAME;
        end
        PH_PTRLO: begin
          r.kind    = KIND_PTRLO;
          r.ptr     = {high_byte[5:0], b};
          rec_phase = PH_TYPE0;
        end
        PH_TYPE0, PH_TYPE1: begin
          r.kind    = KIND_TYPE;
          rec_phase = phase_t'(rec_phase + 4'd1);
        end
        PH_CLASS0: begin
          r.kind    = KIND_CLASS;
          rec_phase = PH_CLASS1;
        end
        PH_CLASS1: begin
          r.kind = KIND_CLASS;
          if (cur_sec == SEC_QD) finish_record();
          else rec_phase = PH_TTL0;
        end
        PH_TTL0, PH_TTL1, PH_TTL2, PH_TTL3: begin
          r.kind    = KIND_TTL;
          rec_phase = phase_t'(rec_phase + 4'd1);
        end
        PH_RDLEN0: begin
          r.kind    = KIND_RDLEN;
          high_byte = b;
          rec_phase = PH_RDLEN1;
        end
        PH_RDLEN1: begin
          r.kind = KIND_RDLEN;
          remain = {high_byte, b};
          if (remain == 16'd0) finish_record();
          else rec_phase = PH_RDATA;
        end
        default: begin
          r.kind = KIND_RDATA;
          remain = remain - 16'd1;
          if (remain == 16'd0) finish_record();
        end
      endcase
    end
    // A message that ends before its structure is complete is truncated.
    if (eop && r.err == ERR_NONE && cur_sec != SEC_TRAIL) r.err = ERR_TRUNC;
    if (eop) clear_parse_state();
    return r;
  endfunction

  // Message construction helpers; they append to pkt_bytes.
  task automatic add_byte(input logic [7:0] v);
    pkt_bytes.insert(pkt_bytes.size(), v);
  endtask

  task automatic put_u16(input logic [15:0] v);
    add_byte(v[15:8]);
    add_byte(v[7:0]);
  endtask

  task automatic put_header(input logic [15:0] qd, an, ns, ar);
    put_u16(16'($urandom));
    put_u16(16'($urandom));
    put_u16(qd);
    put_u16(an);
    put_u16(ns);
    put_u16(ar);
  endtask

  task automatic put_name();
    int labels;
    int len;
    labels = $urandom_range(0, 3);
    repeat (labels) begin
      len = ($urandom_range(0, 15) == 0) ? 63 : $urandom_range(1, 10);
      add_byte(8'(len));
      repeat (len) add_byte(8'($urandom));
    end
    if ($urandom_range(0, 2) == 0) begin
      add_byte(8'($urandom_range(192, 255)));
      add_byte(8'($urandom));
    end else begin
      add_byte(8'h00);
    end
  endtask

  task automatic put_record(input bit is_question);
    int len;
    put_name();
    put_u16(16'($urandom));
    put_u16(16'($urandom));
    if (!is_question) begin
      put_u16(16'($urandom));
      put_u16(16'($urandom));
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      put_u16(16'(len));
      repeat (len) add_byte(8'($urandom));
    end
  endtask

  // A complete message with small random counts and random content.
  task automatic put_message();
    logic [15:0] qd, an, ns, ar;
    qd = 16'($urandom_range(0, 2));
    an = 16'($urandom_range(0, 3));
    ns = 16'($urandom_range(0, 1));
    ar = 16'($urandom_range(0, 2));
    put_header(qd, an, ns, ar);
    repeat (qd) put_record(1'b1);
    repeat (an + ns + ar) put_record(1'b0);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
    end
  endtask

  // Move the built message into the feed, marking its last byte.
  task automatic flush_message(input bit drain_first);
    msg_byte_t m;
    foreach (pkt_bytes[i]) begin
      m.data        = pkt_bytes[i];
      m.eop         = (i == pkt_bytes.size() - 1);
      m.drain_first = drain_first && (i == 0);
      byte_feed_q.insert(byte_feed_q.size(), m);
    end
    pkt_bytes.delete();
  endtask

  // Sender: offers queued bytes, idles in bursts, and predicts each taken byte.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid         <= 1'b0;
      in_data_byte     <= 8'd0;
      in_end_of_packet <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_class_q.insert(expected_class_q.size(),
                                classify_byte(in_data_byte, in_end_of_packet));
        bytes_taken++;
        if (bytes_taken < total_bytes - QUIET_TAIL && (bytes_taken / 250) % 3 != 2 &&
            $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 18);
        end
      end
      if (in_valid && in_stall) begin
        // Hold the offered byte until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_feed_q.size() > 0 &&
                   (!byte_feed_q[0].drain_first || expected_class_q.size() == 0)) begin
        next_byte = byte_feed_q.pop_front();
        in_valid         <= 1'b1;
        in_data_byte     <= next_byte.data;
        in_end_of_packet <= next_byte.eop;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: one long hold-off, random bursts, and quiet stretches.
  int  hold_left = 0;
  int  burst_left = 0;
  int  results_taken = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) results_taken++;
      if (!long_hold_done && results_taken >= 300) begin
        long_hold_done = 1'b1;
        hold_left      = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (results_taken < total_bytes - QUIET_TAIL && (results_taken / 250) % 3 != 1
                   && $urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Monitor: compare each taken result with the oldest expected class.
  byte_class_t want_class;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_class_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual section %0d kind %0d",
                 $time, out_section, out_field_kind);
      end else begin
        want_class = expected_class_q.pop_front();
        check_field("section", want_class.sec, out_section);
        check_field("field_kind", want_class.kind, out_field_kind);
        check_field("pointer_offset", want_class.ptr, out_pointer_offset);
        check_field("error_code", want_class.err, out_error_code);
        check_field("packet_done", want_class.done, out_packet_done);
        results_checked++;
        if (want_class.done) messages_done++;
        if (want_class.err == ERR_TRUNC) truncations++;
        if (want_class.err == ERR_LABEL && want_class.kind == KIND_LABLEN) label_errors++;
        if (want_class.kind == KIND_PTRLO) pointers_seen++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_class_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int pick;
    bit first_random;
    clear_parse_state();

    // All counts zero: the byte after the header is trailing.
    put_header(16'd0, 16'd0, 16'd0, 16'd0);
    add_byte(8'hFF);
    flush_message(1'b0);
    // Question plus an authority record named by the largest pointer.
    put_header(16'd1, 16'd0, 16'd1, 16'd0);
    add_byte(8'h01);
    add_byte(8'h61);
    add_byte(8'h00);
    put_u16(16'h0001);
    put_u16(16'h0001);
    add_byte(8'hFF);
    add_byte(8'hFF);
    put_u16(16'hFFFF);
    put_u16(16'h0000);
    put_u16(16'hFFFF);
    put_u16(16'hFFFF);
    put_u16(16'h0001);
    add_byte(8'h00);
    flush_message(1'b0);
    // Additional record with zero rdlength, ending right on its last byte.
    put_header(16'd0, 16'd0, 16'd0, 16'd1);
    add_byte(8'hC0);
    add_byte(8'h00);
    repeat (5) put_u16(16'h0000);
    flush_message(1'b0);
    // Invalid label lengths at both ends of their range, then ignored bytes.
    put_header(16'd1, 16'd0, 16'd0, 16'd0);
    add_byte(8'h40);
    add_byte(8'h00);
    add_byte(8'hC0);
    flush_message(1'b0);
    put_header(16'd1, 16'd0, 16'd0, 16'd0);
    add_byte(8'hBF);
    flush_message(1'b0);
    // One-byte message, truncated inside the header.
    add_byte(8'h00);
    flush_message(1'b0);

    // Random messages: mostly well formed, some cut short, broken or pure noise.
    first_random = 1'b1;
    while (byte_feed_q.size() < TARGET_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        put_message();
      end else if (pick < 78) begin
        put_message();
        pick = $urandom_range(1, pkt_bytes.size() - 1);
        while (pkt_bytes.size() > pick) void'(pkt_bytes.pop_back());
      end else if (pick < 88) begin
        put_header(16'd1, 16'($urandom), 16'($urandom), 16'($urandom));
        repeat ($urandom_range(0, 2)) begin
          add_byte(8'h02);
          put_u16(16'($urandom));
        end
        add_byte(8'($urandom_range(64, 191)));
        repeat ($urandom_range(0, 5)) add_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 40)) add_byte(8'($urandom));
      end
      flush_message(first_random || $urandom_range(0, 24) == 0);
      first_random = 1'b0;
    end
    total_bytes = byte_feed_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken < total_bytes || expected_class_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d byte classes over %0d messages in %0d cycles.",
             results_checked, messages_done, cycle_count);
    $display("Seen %0d truncated messages, %0d invalid labels, %0d compression pointers.",
             truncations, label_errors, pointers_seen);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
